// File: rtl/i2ctbe_pkg.sv
// i2ctbe_pkg: types and constants of the i2c target bit engine
// shared by i2ctbe_step and i2c_target_bit_engine, depends on nothing
`default_nettype none

package i2ctbe_pkg;

  localparam int unsigned ModeBits  = 3;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned AddrBits  = 7;
  localparam int unsigned CountBits = 4;

  // bus event codes
  localparam logic [ModeBits-1:0] MODE_START    = 3'd0;
  localparam logic [ModeBits-1:0] MODE_STOP     = 3'd1;
  localparam logic [ModeBits-1:0] MODE_SDA_HIGH = 3'd2;
  localparam logic [ModeBits-1:0] MODE_SDA_LOW  = 3'd3;
  localparam logic [ModeBits-1:0] MODE_SCL_FALL = 3'd4;

  localparam logic [CountBits-1:0] BitsPerByte = 4'd8;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ADDR    = 3'd1,
    PH_ACK_OUT = 3'd2,
    PH_RECV    = 3'd3,
    PH_SEND    = 3'd4,
    PH_ACK_IN  = 3'd5
  } phase_e;

  typedef struct packed {
    phase_e               phase;
    logic [ByteBits-1:0]  shift_byte;
    logic [CountBits-1:0] bits_left;
    logic                 ack_flag;
    logic                 direction_flag;
    logic                 sda_level;
  } engine_state_t;

  typedef struct packed {
    logic                sda_release;
    logic                rx_valid;
    logic [ByteBits-1:0] rx_byte;
    logic [ByteBits-1:0] byte_position;
    logic                tx_fetch;
    logic                stop_seen;
    logic                addressed;
    logic                read_transfer;
    phase_e              bus_state;
  } engine_result_t;

endpackage

`default_nettype wire

// File: rtl/i2ctbe_step.sv
// i2ctbe_step: next-state and result logic for one bus event
// depends on i2ctbe_pkg
`default_nettype none

module i2ctbe_step import i2ctbe_pkg::*; #(
  parameter int unsigned INDEX_BITS = 8
) (
  input  engine_state_t         state_i,
  input  logic [INDEX_BITS-1:0] count_i,
  input  logic [AddrBits-1:0]   own_address_i,
  input  logic [ModeBits-1:0]   mode_i,
  input  logic [ByteBits-1:0]   tx_byte_i,
  input  logic                  rx_accept_i,
  output engine_state_t         state_o,
  output logic [INDEX_BITS-1:0] count_o,
  output engine_result_t        result_o
);

  logic [CountBits-1:0] bits_dec;
  logic [2:0]           bit_idx;
  logic [2:0]           fetch_idx;
  logic                 addr_match;

  assign bits_dec   = state_i.bits_left - 4'd1;
  assign bit_idx    = bits_dec[2:0];
  assign fetch_idx  = 3'd7;
  assign addr_match = (state_i.shift_byte[ByteBits-1:1] == own_address_i);

  always_comb begin
    state_o  = state_i;
    count_o  = count_i;
    result_o = '0;

    case (mode_i)
      MODE_START: begin
        state_o.phase      = PH_ADDR;
        state_o.shift_byte = '0;
        state_o.bits_left  = BitsPerByte;
        count_o            = '0;
      end
      MODE_STOP: begin
        state_o.phase     = PH_IDLE;
        state_o.sda_level = 1'b1;
        result_o.stop_seen = 1'b1;
      end
      MODE_SDA_HIGH, MODE_SDA_LOW: begin
        if (state_i.phase inside {PH_ADDR, PH_RECV}) begin
          if (state_i.bits_left != '0) begin
            state_o.bits_left = bits_dec;
            if (mode_i == MODE_SDA_HIGH) begin
              state_o.shift_byte[bit_idx] = 1'b1;
            end
          end
        end else if (state_i.phase == PH_ACK_IN) begin
          state_o.ack_flag = (mode_i == MODE_SDA_LOW);
        end
      end
      MODE_SCL_FALL: begin
        case (state_i.phase)
          PH_ADDR: begin
            if (state_i.bits_left == '0) begin
              state_o.direction_flag = state_i.shift_byte[0];
              state_o.ack_flag       = addr_match;
              state_o.phase          = PH_ACK_OUT;
              state_o.sda_level      = !addr_match;
              result_o.addressed     = addr_match;
            end
          end
          PH_RECV: begin
            if (state_i.bits_left == '0) begin
              result_o.rx_valid      = 1'b1;
              result_o.rx_byte       = state_i.shift_byte;
              result_o.byte_position = ByteBits'(count_i);
              count_o                = count_i + INDEX_BITS'(1);
              state_o.ack_flag       = rx_accept_i;
              state_o.phase          = PH_ACK_OUT;
              state_o.sda_level      = !rx_accept_i;
            end
          end
          PH_ACK_OUT, PH_ACK_IN: begin
            state_o.sda_level = 1'b1;
            if (!state_i.ack_flag) begin
              state_o.phase = PH_IDLE;
            end else if (state_i.phase == PH_ACK_OUT && !state_i.direction_flag) begin
              state_o.phase      = PH_RECV;
              state_o.shift_byte = '0;
              state_o.bits_left  = BitsPerByte;
            end else begin
              // fetch a byte and drive its msb
              state_o.phase          = PH_SEND;
              state_o.shift_byte     = tx_byte_i;
              state_o.bits_left      = BitsPerByte - 4'd1;
              state_o.sda_level      = tx_byte_i[fetch_idx];
              result_o.tx_fetch      = 1'b1;
              result_o.byte_position = ByteBits'(count_i);
              count_o                = count_i + INDEX_BITS'(1);
            end
          end
          PH_SEND: begin
            if (state_i.bits_left != '0) begin
              state_o.bits_left = bits_dec;
              state_o.sda_level = state_i.shift_byte[bit_idx];
            end else begin
              state_o.sda_level = 1'b1;
              state_o.phase     = PH_ACK_IN;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    result_o.sda_release   = state_o.sda_level;
    result_o.read_transfer = state_o.direction_flag;
    result_o.bus_state     = state_o.phase;
  end

endmodule

`default_nettype wire

// File: rtl/i2c_target_bit_engine.sv
// i2c_target_bit_engine: top level of the i2c target bit engine
// depends on i2ctbe_pkg and i2ctbe_step
//
// One bus event (start, stop, sda sampled high or low, scl falling) is taken per
// transfer on the input channel and yields exactly one result transfer. An event
// is registered on entry, runs through the next-state logic and lands in the
// result register, and a new event is taken every cycle while the result side
// keeps up. in_stall_o rises only when both the input and result registers are
// full and out_stall_i is high. own_address is written through the cfg channel,
// which is always ready; write it only while no event is in flight. The byte
// index is INDEX_BITS wide and wraps; byte_position_o shows its low eight bits.
`default_nettype none

module i2c_target_bit_engine import i2ctbe_pkg::*; #(
  parameter int unsigned INDEX_BITS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [AddrBits-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [ModeBits-1:0] mode_i,
  input  logic [ByteBits-1:0] tx_byte_i,
  input  logic                rx_accept_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                sda_release_o,
  output logic                rx_valid_o,
  output logic [ByteBits-1:0] rx_byte_o,
  output logic [ByteBits-1:0] byte_position_o,
  output logic                tx_fetch_o,
  output logic                stop_seen_o,
  output logic                addressed_o,
  output logic                read_transfer_o,
  output logic [2:0]          bus_state_o
);

  logic [AddrBits-1:0]   own_address_q;
  logic                  in_full_q;
  logic [ModeBits-1:0]   mode_q;
  logic [ByteBits-1:0]   tx_byte_q;
  logic                  rx_accept_q;
  engine_state_t         state_q, state_d;
  logic [INDEX_BITS-1:0] count_q, count_d;
  logic                  out_full_q;
  engine_result_t        result_q, result_d;
  logic                  out_free;
  logic                  in_take;
  logic                  advance;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_full_q || !out_stall_i;
  assign advance     = in_full_q && out_free;
  assign in_stall_o  = in_full_q && !out_free;
  assign in_take     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_address_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      own_address_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_take) begin
      in_full_q <= 1'b1;
    end else if (advance) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mode_q      <= mode_i;
      tx_byte_q   <= tx_byte_i;
      rx_accept_q <= rx_accept_i;
    end
  end

  i2ctbe_step #(
    .INDEX_BITS(INDEX_BITS)
  ) u_step (
    .state_i      (state_q),
    .count_i      (count_q),
    .own_address_i(own_address_q),
    .mode_i       (mode_q),
    .tx_byte_i    (tx_byte_q),
    .rx_accept_i  (rx_accept_q),
    .state_o      (state_d),
    .count_o      (count_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase          <= PH_IDLE;
      state_q.shift_byte     <= '0;
      state_q.bits_left      <= '0;
      state_q.ack_flag       <= 1'b0;
      state_q.direction_flag <= 1'b0;
      state_q.sda_level      <= 1'b1;
      count_q                <= '0;
    end else if (advance) begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else if (out_free) begin
      out_full_q <= in_full_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_full_q;
  assign sda_release_o   = result_q.sda_release;
  assign rx_valid_o      = result_q.rx_valid;
  assign rx_byte_o       = result_q.rx_byte;
  assign byte_position_o = result_q.byte_position;
  assign tx_fetch_o      = result_q.tx_fetch;
  assign stop_seen_o     = result_q.stop_seen;
  assign addressed_o     = result_q.addressed;
  assign read_transfer_o = result_q.read_transfer;
  assign bus_state_o     = result_q.bus_state;

  // a byte is never received and fetched by the same event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rx_valid_o && tx_fetch_o))
    else $error("rx_valid and tx_fetch together");

  // stop always leaves the engine idle with sda released
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && stop_seen_o) |-> (bus_state_o == PH_IDLE && sda_release_o))
    else $error("stop did not return to idle");

  // an address match drives the ack low
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && addressed_o) |-> (bus_state_o == PH_ACK_OUT && !sda_release_o))
    else $error("address match without ack");

  // the bit counter never exceeds one byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.bits_left <= BitsPerByte)
    else $error("bit counter out of range");

  // result register is refilled only from a held input item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_full_q && !in_full_q) |=> !out_full_q)
    else $error("result without input item");

endmodule

`default_nettype wire

// File: tb/sv/i2c_target_bit_engine_tb.sv
`timescale 1ns / 1ps
// i2c_target_bit_engine_tb: self-checking testbench of the i2c target bit engine
// feeds bus event sequences through a queue-fed driver and checks every result
// against a cycle-free model of the engine; depends on i2ctbe_pkg and the rtl

module i2c_target_bit_engine_tb;
  import i2ctbe_pkg::*;

  localparam int unsigned IndexBits = 8;
  localparam logic [ModeBits-1:0] MODE_UNDEF_FIRST = 3'd5;
  localparam logic [ModeBits-1:0] MODE_UNDEF_LAST  = 3'd7;

  typedef struct packed {
    logic [ModeBits-1:0] mode;
    logic [ByteBits-1:0] tx;
    logic                accept;
  } bus_item_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [AddrBits-1:0] cfg_data_i = '0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [ModeBits-1:0] mode_i = MODE_STOP;
  logic [ByteBits-1:0] tx_byte_i = '0;
  logic                rx_accept_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                sda_release_o;
  logic                rx_valid_o;
  logic [ByteBits-1:0] rx_byte_o;
  logic [ByteBits-1:0] byte_position_o;
  logic                tx_fetch_o;
  logic                stop_seen_o;
  logic                addressed_o;
  logic                read_transfer_o;
  logic [2:0]          bus_state_o;

  i2c_target_bit_engine #(
    .INDEX_BITS(IndexBits)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .tx_byte_i      (tx_byte_i),
    .rx_accept_i    (rx_accept_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sda_release_o  (sda_release_o),
    .rx_valid_o     (rx_valid_o),
    .rx_byte_o      (rx_byte_o),
    .byte_position_o(byte_position_o),
    .tx_fetch_o     (tx_fetch_o),
    .stop_seen_o    (stop_seen_o),
    .addressed_o    (addressed_o),
    .read_transfer_o(read_transfer_o),
    .bus_state_o    (bus_state_o)
  );

  always #10 clk_i = ~clk_i;

  // engine model state
  logic [AddrBits-1:0]  own_addr = '0;
  phase_e               eng_phase = PH_IDLE;
  logic [ByteBits-1:0]  eng_shift = '0;
  logic [CountBits-1:0] eng_bits = '0;
  logic [IndexBits-1:0] eng_count = '0;
  logic                 eng_ack = 1'b0;
  logic                 eng_dir = 1'b0;
  logic                 eng_sda = 1'b1;

  bus_item_t      bus_event_queue[$];
  engine_result_t bus_results_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_pushed = 0;
  int items_accepted = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  int errors = 0;
  int bytes_received = 0;
  int bytes_fetched = 0;
  int address_hits = 0;
  int cut_left = -1;
  int noise_pct = 0;
  logic in_fire = 1'b0;

  bus_item_t      drv_item;
  bus_item_t      mon_item;
  engine_result_t due;
  engine_result_t got;

  function automatic logic [ByteBits-1:0] start_send(input logic [ByteBits-1:0] tx);
    logic [ByteBits-1:0] pos;
    pos = ByteBits'(eng_count);
    eng_phase = PH_SEND;
    eng_shift = tx;
    eng_count = eng_count + 1'b1;
    eng_bits = BitsPerByte - 1'b1;
    eng_sda = tx[eng_bits];
    return pos;
  endfunction

  function automatic engine_result_t bus_event_result(input bus_item_t ev);
    engine_result_t r;
    logic bit_in;
    r = '0;
    case (ev.mode)
      MODE_START: begin
        eng_phase = PH_ADDR;
        eng_shift = '0;
        eng_bits = BitsPerByte;
        eng_count = '0;
      end
      MODE_STOP: begin
        eng_phase = PH_IDLE;
        eng_sda = 1'b1;
        r.stop_seen = 1'b1;
      end
      MODE_SDA_HIGH, MODE_SDA_LOW: begin
        bit_in = (ev.mode == MODE_SDA_HIGH);
        if (eng_phase == PH_ADDR || eng_phase == PH_RECV) begin
          if (eng_bits != 0) begin
            eng_bits = eng_bits - 1'b1;
            if (bit_in) eng_shift[eng_bits] = 1'b1;
          end
        end else if (eng_phase == PH_ACK_IN) begin
          eng_ack = ~bit_in;
        end
      end
      MODE_SCL_FALL: begin
        case (eng_phase)
          PH_ADDR: begin
            if (eng_bits == 0) begin
              eng_dir = eng_shift[0];
              eng_ack = (eng_shift[7:1] == own_addr);
              r.addressed = eng_ack;
              eng_phase = PH_ACK_OUT;
              eng_sda = ~eng_ack;
            end
          end
          PH_RECV: begin
            if (eng_bits == 0) begin
              r.rx_valid = 1'b1;
              r.rx_byte = eng_shift;
              r.byte_position = ByteBits'(eng_count);
              eng_count = eng_count + 1'b1;
              eng_ack = ev.accept;
              eng_phase = PH_ACK_OUT;
              eng_sda = ~eng_ack;
            end
          end
          PH_ACK_OUT: begin
            eng_sda = 1'b1;
            if (!eng_ack) begin
              eng_phase = PH_IDLE;
            end else if (eng_dir) begin
              r.byte_position = start_send(ev.tx);
              r.tx_fetch = 1'b1;
            end else begin
              eng_phase = PH_RECV;
              eng_shift = '0;
              eng_bits = BitsPerByte;
            end
          end
          PH_SEND: begin
            if (eng_bits != 0) begin
              eng_bits = eng_bits - 1'b1;
              eng_sda = eng_shift[eng_bits];
            end else begin
              eng_sda = 1'b1;
              eng_phase = PH_ACK_IN;
            end
          end
          PH_ACK_IN: begin
            if (eng_ack) begin
              r.byte_position = start_send(ev.tx);
              r.tx_fetch = 1'b1;
            end else begin
              eng_phase = PH_IDLE;
              eng_sda = 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    r.sda_release = eng_sda;
    r.read_transfer = eng_dir;
    r.bus_state = eng_phase;
    return r;
  endfunction

  // driver: new item only once the previous one has been transferred
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (bus_event_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_item = bus_event_queue.pop_front();
        in_valid_i <= 1'b1;
        mode_i <= drv_item.mode;
        tx_byte_i <= drv_item.tx;
        rx_accept_i <= drv_item.accept;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_idle_pct);
  end

  // monitor: model runs on each input transfer, results checked in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if (cfg_valid_i && cfg_ready_o) begin
        own_addr = cfg_data_i;
        cfg_writes <= cfg_writes + 1;
      end
      if (in_valid_i && !in_stall_o) begin
        mon_item = {mode_i, tx_byte_i, rx_accept_i};
        bus_results_due.push_back(bus_event_result(mon_item));
        items_accepted <= items_accepted + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        got = {sda_release_o, rx_valid_o, rx_byte_o, byte_position_o, tx_fetch_o,
               stop_seen_o, addressed_o, read_transfer_o, bus_state_o};
        if (bus_results_due.size() == 0) begin
          errors++;
          if (errors <= 10) $display("result %0d arrived with nothing outstanding", results_seen);
        end else begin
          due = bus_results_due.pop_front();
          bytes_received += due.rx_valid;
          bytes_fetched += due.tx_fetch;
          address_hits += due.addressed;
          if (got !== due) begin
            errors++;
            if (errors <= 10) begin
              $display("result %0d mismatch (sda rxv rxb pos fetch stop adr rd state)",
                       results_seen);
              $display("  expected %b %b %h %h %b %b %b %b %0d", due.sda_release,
                       due.rx_valid, due.rx_byte, due.byte_position, due.tx_fetch,
                       due.stop_seen, due.addressed, due.read_transfer, due.bus_state);
              $display("  actual   %b %b %h %h %b %b %b %b %0d", got.sda_release,
                       got.rx_valid, got.rx_byte, got.byte_position, got.tx_fetch,
                       got.stop_seen, got.addressed, got.read_transfer, got.bus_state);
            end
          end
        end
        results_seen <= results_seen + 1;
      end
    end
  end

  task automatic push_item(input logic [ModeBits-1:0] m, input logic [ByteBits-1:0] tx,
                           input logic acc);
    bus_item_t it;
    it.mode = m;
    it.tx = tx;
    it.accept = acc;
    bus_event_queue.push_back(it);
    items_pushed++;
  endtask

  // random content, stray samples, and an optional cut-off for broken sequences
  task automatic push_ev(input logic [ModeBits-1:0] m);
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    if ($urandom_range(99) < noise_pct)
      push_item($urandom_range(1) ? MODE_SDA_HIGH : MODE_SDA_LOW, 8'($urandom),
                1'($urandom));
    push_item(m, 8'($urandom), $urandom_range(99) < 85);
  endtask

  task automatic run_transaction(input bit long_read);
    logic [ByteBits-1:0] addr_byte;
    logic [ByteBits-1:0] data;
    int nbytes;
    int pick;
    if (!long_read && $urandom_range(99) < 8) begin
      repeat ($urandom_range(6, 1))
        push_item(ModeBits'($urandom_range(MODE_UNDEF_LAST, MODE_START)), 8'($urandom),
                  1'($urandom));
      return;
    end
    cut_left = (!long_read && $urandom_range(99) < 10) ? $urandom_range(40, 1) : -1;
    noise_pct = long_read ? 0 : 2;
    addr_byte[7:1] = (long_read || $urandom_range(99) < 80) ? own_addr : 7'($urandom);
    addr_byte[0] = long_read ? 1'b1 : 1'($urandom);
    nbytes = long_read ? 257 : $urandom_range(4, 1);
    push_ev(MODE_START);
    for (int i = 7; i >= 0; i--) begin
      push_ev(addr_byte[i] ? MODE_SDA_HIGH : MODE_SDA_LOW);
      push_ev(MODE_SCL_FALL);
    end
    for (int b = 0; b < nbytes; b++) begin
      if (addr_byte[0]) begin
        repeat (9) push_ev(MODE_SCL_FALL);
        pick = $urandom_range(99);
        if (b == nbytes - 1) begin
          if (pick < 85) push_ev(MODE_SDA_HIGH);
        end else if (long_read) begin
          if (pick < 20) push_ev(MODE_SDA_LOW);
        end else if (pick < 70) begin
          push_ev(MODE_SDA_LOW);
        end else if (pick < 85) begin
          push_ev(MODE_SDA_HIGH);
        end
      end else begin
        push_ev(MODE_SCL_FALL);
        data = 8'($urandom);
        for (int i = 7; i >= 0; i--) begin
          push_ev(data[i] ? MODE_SDA_HIGH : MODE_SDA_LOW);
          push_ev(MODE_SCL_FALL);
        end
      end
    end
    push_ev(MODE_SCL_FALL);
    cut_left = -1;
    if ($urandom_range(99) < 85) push_ev(MODE_STOP);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (results_seen < items_pushed);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_own_address(input logic [AddrBits-1:0] addr);
    int prior;
    prior = cfg_writes;
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= addr;
    wait (cfg_writes != prior);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int target;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: undefined codes, ignored events, a read with held drive and restart
    write_own_address(7'h7f);
    for (int m = MODE_UNDEF_FIRST; m <= MODE_UNDEF_LAST; m++)
      push_item(ModeBits'(m), 8'hff, 1'b1);
    push_item(MODE_SDA_HIGH, 8'h00, 1'b0);
    push_item(MODE_SDA_LOW, 8'h00, 1'b0);
    push_item(MODE_SCL_FALL, 8'h00, 1'b0);
    push_item(MODE_STOP, 8'h00, 1'b0);
    push_item(MODE_START, 8'h00, 1'b0);
    repeat (8) push_item(MODE_SDA_HIGH, 8'hff, 1'b1);
    push_item(MODE_SDA_LOW, 8'hff, 1'b1);
    push_item(MODE_SCL_FALL, 8'hff, 1'b1);
    push_item(MODE_SDA_LOW, 8'hff, 1'b1);
    push_item(MODE_SCL_FALL, 8'h00, 1'b0);
    push_item(MODE_SDA_HIGH, 8'hff, 1'b1);
    push_item(MODE_START, 8'hff, 1'b1);
    push_item(MODE_SCL_FALL, 8'hff, 1'b1);
    push_item(MODE_STOP, 8'hff, 1'b0);
    wait_drained();

    for (int regime = 0; regime < 3; regime++) begin
      send_idle_pct = (regime == 0) ? 25 : (regime == 1) ? 58 : 0;
      recv_idle_pct = (regime == 0) ? 58 : (regime == 1) ? 25 : 0;
      write_own_address((regime == 0) ? 7'h00 : 7'($urandom));
      target = items_pushed + 430;
      while (items_pushed < target) run_transaction(1'b0);
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (bus_results_due.size() != 0) errors++;
    $display("%0d bus events over four address settings and three idle patterns,",
             items_accepted);
    $display("%0d address matches, %0d bytes received, %0d bytes fetched, %0d errors",
             address_hits, bytes_received, bytes_fetched, errors);
    if (errors == 0) begin
      $display("PASS i2c_target_bit_engine");
    end else begin
      $display("FAIL i2c_target_bit_engine");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAIL i2c_target_bit_engine");
    $finish;
  end

endmodule

// File: sim.f
rtl/i2ctbe_pkg.sv
rtl/i2ctbe_step.sv
rtl/i2c_target_bit_engine.sv
tb/sv/i2c_target_bit_engine_tb.sv
